/* hw/rtl/twlp_pkg.sv */
// Shared types and codes for the word, line and paragraph scanner.
package twlp_pkg;

    // Byte class codes, plain form odd and pattern-start form even
    localparam logic [4:0] CLASS_NUL       = 5'd0;
    localparam logic [4:0] CLASS_DASH      = 5'd13;
    localparam logic [4:0] CLASS_DASH_PAT  = 5'd14;
    localparam logic [4:0] CLASS_OTHER     = 5'd23;
    localparam logic [4:0] CLASS_LAST      = 5'd24;
    localparam logic [4:0] CLASS_SPACE_PAT = 5'd2;
    localparam logic [4:0] CLASS_NL_PAT    = 5'd4;
    localparam logic [4:0] CLASS_FF_PAT    = 5'd6;

    // Scanner states
    typedef enum logic [2:0] {
        ST_SPACE  = 3'd0,
        ST_WORD   = 3'd1,
        ST_LINE   = 3'd2,
        ST_PSPACE = 3'd3,
        ST_PWORD  = 3'd4,
        ST_PLINE  = 3'd5
    } scan_state_t;

    // Commands for the external pattern matcher
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_FIRST = 3'd1,
        CMD_NEXT  = 3'd2,
        CMD_SPACE = 3'd3,
        CMD_MAYBE = 3'd4
    } cmd_t;

    // Class groups that steer the scanner
    typedef enum logic [2:0] {
        GRP_NUL   = 3'd0,
        GRP_SPC   = 3'd1,
        GRP_NL    = 3'd2,
        GRP_FF    = 3'd3,
        GRP_DASH  = 3'd4,
        GRP_PLAIN = 3'd5,
        GRP_PAT   = 3'd6
    } class_group_t;

    // One input word: a byte's class and the buffer-end flag
    typedef struct packed {
        logic [4:0] char_class;
        logic       at_buffer_end;
    } scan_in_t;

    // One result word
    typedef struct packed {
        logic [2:0]  matcher_command;
        logic        stopped;
        logic [31:0] words_seen;
        logic [31:0] lines_seen;
        logic [31:0] paragraphs_seen;
        logic [31:0] bytes_seen;
    } scan_out_t;

    // Map a raw class code to its group; out-of-range codes act as plain other
    function automatic class_group_t group_of(input logic [4:0] cls);
        logic [4:0] c;
        begin
            c = (cls > CLASS_LAST) ? CLASS_OTHER : cls;
            if (c == CLASS_NUL)
                return GRP_NUL;
            else if (c <= CLASS_SPACE_PAT)
                return GRP_SPC;
            else if (c <= CLASS_NL_PAT)
                return GRP_NL;
            else if (c <= CLASS_FF_PAT)
                return GRP_FF;
            else if (c == CLASS_DASH || c == CLASS_DASH_PAT)
                return GRP_DASH;
            else if (!c[0])
                return GRP_PAT;
            else
                return GRP_PLAIN;
        end
    endfunction

    // Pattern-start form: nonzero, even class code
    function automatic logic is_pattern(input logic [4:0] cls);
        logic [4:0] c;
        begin
            c = (cls > CLASS_LAST) ? CLASS_OTHER : cls;
            return (c != CLASS_NUL) && !c[0];
        end
    endfunction

endpackage

/* hw/rtl/twlp_stream_if.sv */
// Valid/ready stream channel carrying one payload word per handshake.
interface twlp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/text_word_line_paragraph_scanner_top.sv */
// Word, line and paragraph scanner: class decode, scan state, counters and result register.
//
// Takes one byte class word per cycle on text_in while count_out does not stall, and
// returns one result word per input on count_out: the matcher command, the stop flag
// and the word, line, paragraph and byte counts after that byte (low 32 bits of
// COUNT_WIDTH-bit saturating counters). A byte goes through an input register, and
// its result through a result register, before the result appears on count_out.
// A sentinel NUL (class NUL with the buffer-end flag) returns stopped = 1 and changes
// no count or state. count_out stalls hold results; an empty input register still
// takes a byte while a result waits.
module text_word_line_paragraph_scanner_top
    import twlp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    twlp_stream_if.sink   text_in,
    twlp_stream_if.source count_out
);

    // Counter value as a 32-bit result field
    function automatic logic [31:0] to_field(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+31:0] wide;
        begin
            wide = {32'b0, c};
            return wide[31:0];
        end
    endfunction

    // Input register
    logic        in_valid_reg;
    scan_in_t    in_word_reg;

    // Result register
    logic        out_valid_reg;
    scan_out_t   out_word_reg;
    scan_out_t   out_word_next;

    // Scanner state and counters
    scan_state_t            state_reg, state_next;
    logic [COUNT_WIDTH-1:0] word_cnt_reg, word_cnt_next;
    logic [COUNT_WIDTH-1:0] line_cnt_reg, line_cnt_next;
    logic [COUNT_WIDTH-1:0] para_cnt_reg, para_cnt_next;
    logic [COUNT_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;

    logic         advance;
    class_group_t grp;
    logic         pat;
    logic         sentinel;
    logic         word_inc, line_inc, para_inc, byte_inc;
    cmd_t         cmd;

    // Handshake: result register frees when empty or taken
    assign advance       = !out_valid_reg || count_out.ready;
    assign text_in.ready = !in_valid_reg || advance;

    assign grp      = group_of(in_word_reg.char_class);
    assign pat      = is_pattern(in_word_reg.char_class);
    assign sentinel = (grp == GRP_NUL) && in_word_reg.at_buffer_end;

    // Scan step: next state, counter bumps and matcher command
    always_comb
    begin
        state_next = state_reg;
        word_inc   = 1'b0;
        line_inc   = 1'b0;
        para_inc   = 1'b0;
        byte_inc   = !sentinel;
        cmd        = CMD_NONE;
        if (!sentinel && grp != GRP_NUL)
        begin
            case (state_reg)
                ST_PSPACE, ST_PLINE:
                begin
                    if (grp == GRP_NL)
                    begin
                        line_inc = 1'b1;
                        if (state_reg == ST_PLINE)
                        begin
                            para_inc   = 1'b1;
                            state_next = ST_LINE;
                        end
                        else
                        begin
                            state_next = ST_PLINE;
                        end
                    end
                    else if (grp == GRP_FF)
                    begin
                        para_inc   = 1'b1;
                        state_next = ST_SPACE;
                    end
                    else if (grp != GRP_SPC)
                    begin
                        word_inc   = 1'b1;
                        state_next = ST_PWORD;
                        cmd        = CMD_NEXT;
                    end
                end
                ST_PWORD:
                begin
                    case (grp)
                        GRP_SPC:
                        begin
                            state_next = ST_PSPACE;
                            cmd        = CMD_SPACE;
                        end
                        GRP_NL:
                        begin
                            line_inc   = 1'b1;
                            state_next = ST_PLINE;
                            cmd        = CMD_SPACE;
                        end
                        GRP_FF:
                        begin
                            para_inc   = 1'b1;
                            state_next = ST_SPACE;
                        end
                        GRP_DASH:
                        begin
                            state_next = ST_PSPACE;
                            cmd        = CMD_MAYBE;
                        end
                        default:
                        begin
                            cmd = CMD_NEXT;
                        end
                    endcase
                end
                ST_WORD:
                begin
                    if (grp == GRP_SPC || grp == GRP_FF)
                    begin
                        state_next = ST_SPACE;
                    end
                    else if (grp == GRP_NL)
                    begin
                        line_inc   = 1'b1;
                        state_next = ST_LINE;
                    end
                    else if (pat)
                    begin
                        state_next = ST_PWORD;
                        cmd        = CMD_FIRST;
                    end
                end
                default:
                begin
                    // space, line, and any unused code acting as space
                    if (grp == GRP_NL)
                    begin
                        line_inc   = 1'b1;
                        para_inc   = (state_reg == ST_LINE);
                        state_next = ST_LINE;
                    end
                    else if (grp == GRP_FF)
                    begin
                        para_inc   = 1'b1;
                        state_next = (state_reg == ST_LINE) ? ST_LINE : ST_SPACE;
                    end
                    else if (grp != GRP_SPC)
                    begin
                        word_inc   = 1'b1;
                        if (pat)
                        begin
                            state_next = ST_PWORD;
                            cmd        = CMD_FIRST;
                        end
                        else
                        begin
                            state_next = ST_WORD;
                        end
                    end
                    else
                    begin
                        state_next = (state_reg == ST_LINE) ? ST_LINE : ST_SPACE;
                    end
                end
            endcase
        end
    end

    // Saturating counter updates
    always_comb
    begin
        word_cnt_next = word_cnt_reg + COUNT_WIDTH'(word_inc && (word_cnt_reg != '1));
        line_cnt_next = line_cnt_reg + COUNT_WIDTH'(line_inc && (line_cnt_reg != '1));
        para_cnt_next = para_cnt_reg + COUNT_WIDTH'(para_inc && (para_cnt_reg != '1));
        byte_cnt_next = byte_cnt_reg + COUNT_WIDTH'(byte_inc && (byte_cnt_reg != '1));
    end

    // Assemble the result word
    always_comb
    begin
        out_word_next.matcher_command = cmd;
        out_word_next.stopped         = sentinel;
        out_word_next.words_seen      = to_field(word_cnt_next);
        out_word_next.lines_seen      = to_field(line_cnt_next);
        out_word_next.paragraphs_seen = to_field(para_cnt_next);
        out_word_next.bytes_seen      = to_field(byte_cnt_next);
    end

    // Control: valid flags, scan state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_SPACE;
            word_cnt_reg  <= '0;
            line_cnt_reg  <= '0;
            para_cnt_reg  <= '0;
            byte_cnt_reg  <= '0;
        end
        else
        begin
            if (text_in.ready)
            begin
                in_valid_reg <= text_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                state_reg    <= state_next;
                word_cnt_reg <= word_cnt_next;
                line_cnt_reg <= line_cnt_next;
                para_cnt_reg <= para_cnt_next;
                byte_cnt_reg <= byte_cnt_next;
            end
        end
    end

    // Payload registers: load input word and result word
    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            in_word_reg <= text_in.payload;
        end
        if (advance && in_valid_reg)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign count_out.valid   = out_valid_reg;
    assign count_out.payload = out_word_reg;

    // A stopped result never carries a matcher command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.stopped) |-> (out_word_reg.matcher_command == CMD_NONE))
        else $error("stopped result carries a matcher command");

    // The sentinel leaves state and byte count untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && sentinel)
        |=> (byte_cnt_reg == $past(byte_cnt_reg)) && (state_reg == $past(state_reg)))
        else $error("sentinel changed scanner state or byte count");

    // Word count grows by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((word_cnt_reg == $past(word_cnt_reg))
            || (word_cnt_reg == $past(word_cnt_reg) + COUNT_WIDTH'(1))))
        else $error("word counter jumped");

endmodule

/* verif/tb_text_word_line_paragraph_scanner_top.sv */
// Self-checking testbench for the word, line and paragraph scanner top level.
`timescale 1ns / 100ps

module tb_text_word_line_paragraph_scanner_top;
    import twlp_pkg::*;

    localparam int COUNT_W = 32;
    localparam int ITEMS   = 1000;
    localparam int CALM_TAIL = 120;

    // Byte classes the package does not name: plain, pattern-start and out-of-range codes
    localparam logic [4:0] CL_SPACE  = 5'd1;
    localparam logic [4:0] CL_NL     = 5'd3;
    localparam logic [4:0] CL_FF     = 5'd5;
    localparam logic [4:0] CL_QUOTE  = 5'd7;
    localparam logic [4:0] CL_QUOTE_PAT  = 5'd8;
    localparam logic [4:0] CL_DIGIT  = 5'd15;
    localparam logic [4:0] CL_LETTER = 5'd21;
    localparam logic [4:0] CL_LETTER_PAT = 5'd22;
    localparam logic [4:0] CL_OVER   = 5'd25;
    localparam logic [4:0] CL_TOP    = 5'd31;

    // Predicts scanner results and checks them in order
    class scan_ledger;
        scan_state_t            state;
        logic [COUNT_W-1:0]     words;
        logic [COUNT_W-1:0]     lines;
        logic [COUNT_W-1:0]     paras;
        logic [COUNT_W-1:0]     bytes;
        scan_out_t              owed[$];
        int                     mismatches;
        int                     results;

        function new();
            state      = ST_SPACE;
            words      = '0;
            lines      = '0;
            paras      = '0;
            bytes      = '0;
            mismatches = 0;
            results    = 0;
        endfunction

        function void step_count(inout logic [COUNT_W-1:0] c);
            if (c != '1)
                c = c + 1'b1;
        endfunction

        // Advance the scanner by one accepted word and queue its result
        function void note_byte(scan_in_t w);
            logic [4:0]   c;
            class_group_t grp;
            bit           pat;
            cmd_t         cmd;
            bit           stop;
            scan_out_t    want;

            c   = (w.char_class > CLASS_LAST) ? CLASS_OTHER : w.char_class;
            pat = (c != CLASS_NUL) && !c[0];
            if (c == CLASS_NUL)
                grp = GRP_NUL;
            else if (c <= CLASS_SPACE_PAT)
                grp = GRP_SPC;
            else if (c <= CLASS_NL_PAT)
                grp = GRP_NL;
            else if (c <= CLASS_FF_PAT)
                grp = GRP_FF;
            else if (c == CLASS_DASH || c == CLASS_DASH_PAT)
                grp = GRP_DASH;
            else
                grp = pat ? GRP_PAT : GRP_PLAIN;

            cmd  = CMD_NONE;
            stop = 1'b0;
            if (grp == GRP_NUL && w.at_buffer_end)
            begin
                stop = 1'b1;
            end
            else
            begin
                step_count(bytes);
                if (grp != GRP_NUL)
                begin
                    case (state)
                        ST_PSPACE, ST_PLINE:
                        begin
                            if (grp == GRP_NL)
                            begin
                                if (state == ST_PLINE)
                                begin
                                    step_count(paras);
                                    state = ST_LINE;
                                end
                                else
                                begin
                                    state = ST_PLINE;
                                end
                                step_count(lines);
                            end
                            else if (grp == GRP_FF)
                            begin
                                step_count(paras);
                                state = ST_SPACE;
                            end
                            else if (grp != GRP_SPC)
                            begin
                                step_count(words);
                                state = ST_PWORD;
                                cmd   = CMD_NEXT;
                            end
                        end
                        ST_PWORD:
                        begin
                            if (grp == GRP_SPC)
                            begin
                                state = ST_PSPACE;
                                cmd   = CMD_SPACE;
                            end
                            else if (grp == GRP_NL)
                            begin
                                step_count(lines);
                                state = ST_PLINE;
                                cmd   = CMD_SPACE;
                            end
                            else if (grp == GRP_FF)
                            begin
                                step_count(paras);
                                state = ST_SPACE;
                            end
                            else if (grp == GRP_DASH)
                            begin
                                state = ST_PSPACE;
                                cmd   = CMD_MAYBE;
                            end
                            else
                            begin
                                cmd = CMD_NEXT;
                            end
                        end
                        ST_WORD:
                        begin
                            if (grp == GRP_SPC || grp == GRP_FF)
                            begin
                                state = ST_SPACE;
                            end
                            else if (grp == GRP_NL)
                            begin
                                step_count(lines);
                                state = ST_LINE;
                            end
                            else if (pat)
                            begin
                                state = ST_PWORD;
                                cmd   = CMD_FIRST;
                            end
                        end
                        default:
                        begin
                            // space and line states
                            if (grp == GRP_NL)
                            begin
                                step_count(lines);
                                if (state == ST_LINE)
                                    step_count(paras);
                                state = ST_LINE;
                            end
                            else if (grp == GRP_FF)
                            begin
                                step_count(paras);
                            end
                            else if (grp != GRP_SPC)
                            begin
                                step_count(words);
                                if (pat)
                                begin
                                    state = ST_PWORD;
                                    cmd   = CMD_FIRST;
                                end
                                else
                                begin
                                    state = ST_WORD;
                                end
                            end
                        end
                    endcase
                end
            end

            want.matcher_command = cmd;
            want.stopped         = stop;
            want.words_seen      = words[31:0];
            want.lines_seen      = lines[31:0];
            want.paragraphs_seen = paras[31:0];
            want.bytes_seen      = bytes[31:0];
            owed.push_back(want);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("%0t ns: result %0d, %s: got %0d, want %0d",
                     $time, results, field, got, want);
        endtask

        // Compare one accepted result with the oldest prediction
        task check_result(scan_out_t got);
            scan_out_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("result with nothing owed", got.bytes_seen, 32'd0);
            end
            else
            begin
                want = owed.pop_front();
                if (got.matcher_command !== want.matcher_command)
                    report_mismatch("matcher_command", 32'(got.matcher_command),
                                    32'(want.matcher_command));
                if (got.stopped !== want.stopped)
                    report_mismatch("stopped", 32'(got.stopped), 32'(want.stopped));
                if (got.words_seen !== want.words_seen)
                    report_mismatch("words_seen", got.words_seen, want.words_seen);
                if (got.lines_seen !== want.lines_seen)
                    report_mismatch("lines_seen", got.lines_seen, want.lines_seen);
                if (got.paragraphs_seen !== want.paragraphs_seen)
                    report_mismatch("paragraphs_seen", got.paragraphs_seen,
                                    want.paragraphs_seen);
                if (got.bytes_seen !== want.bytes_seen)
                    report_mismatch("bytes_seen", got.bytes_seen, want.bytes_seen);
            end
            results++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;
    int   fed = 0;

    scan_ledger ledger = new();

    twlp_stream_if #(.payload_t(scan_in_t))  text_in ();
    twlp_stream_if #(.payload_t(scan_out_t)) count_out ();

    text_word_line_paragraph_scanner_top #(
        .COUNT_WIDTH (COUNT_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .count_out (count_out)
    );

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one word, with an optional idle burst first, and hold until taken
    task automatic feed(input logic [4:0] cls, input logic flag);
        scan_in_t w;
        w.char_class    = cls;
        w.at_buffer_end = flag;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            text_in.valid   <= 1'b0;
            text_in.payload <= scan_in_t'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        text_in.valid   <= 1'b1;
        text_in.payload <= w;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        ledger.note_byte(w);
        fed++;
    endtask

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && count_out.valid === 1'b1 && count_out.ready === 1'b1)
            ledger.check_result(count_out.payload);
    end

    // Drive result ready: stall bursts and open runs
    initial
    begin
        count_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                count_out.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                count_out.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Main stimulus
    initial
    begin
        int         pick;
        int         len;
        int         sep;
        logic [4:0] cls;

        text_in.valid   <= 1'b0;
        text_in.payload <= '0;
        rst_n           <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sentinel right after reset, NUL inside the buffer
        feed(CLASS_NUL, 1'b1);
        feed(CLASS_NUL, 1'b0);
        feed(CL_SPACE, 1'b0);
        // word, then pattern start inside it, next, dash
        feed(CL_LETTER, 1'b0);
        feed(CL_LETTER_PAT, 1'b0);
        feed(CL_DIGIT, 1'b0);
        feed(CLASS_DASH, 1'b0);
        feed(CL_LETTER_PAT, 1'b0);
        feed(CLASS_SPACE_PAT, 1'b0);
        // newline pairs make paragraphs from pattern and plain line states
        feed(CL_NL, 1'b0);
        feed(CLASS_NL_PAT, 1'b0);
        feed(CL_NL, 1'b0);
        feed(CL_FF, 1'b0);
        // out-of-range classes act as plain other; end flag ignored off NUL
        feed(CL_TOP, 1'b1);
        feed(CL_NL, 1'b0);
        feed(CL_OVER, 1'b0);
        feed(CLASS_FF_PAT, 1'b0);
        feed(CL_QUOTE_PAT, 1'b0);
        feed(CL_NL, 1'b0);
        feed(CL_LETTER, 1'b0);
        feed(CL_FF, 1'b0);
        feed(CLASS_NUL, 1'b1);
        feed(CLASS_DASH_PAT, 1'b0);
        feed(CLASS_FF_PAT, 1'b1);
        feed(CLASS_LAST, 1'b0);
        feed(CL_SPACE, 1'b0);
        feed(CL_FF, 1'b0);

        // Random: mostly words and separators, some noise and sentinels
        while (fed < ITEMS)
        begin
            if (fed >= ITEMS - CALM_TAIL)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                feed(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 15)
            begin
                feed(CLASS_NUL, 1'b1);
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        cls = CLASS_DASH + 5'($urandom_range(0, 1));
                    end
                    else
                    begin
                        cls = CL_QUOTE + 5'(2 * $urandom_range(0, 8));
                        if (cls == CLASS_DASH)
                            cls = CL_LETTER;
                        // pattern-start form
                        if ($urandom_range(0, 3) == 0)
                            cls = cls + 5'd1;
                    end
                    feed(cls, $urandom_range(0, 15) == 0);
                end
                sep = $urandom_range(0, 99);
                if (sep < 50)
                    repeat ($urandom_range(1, 3)) feed(CL_SPACE + 5'($urandom_range(0, 1)), 1'b0);
                else if (sep < 80)
                    feed(CL_NL + 5'($urandom_range(0, 1)), 1'b0);
                else if (sep < 93)
                    repeat (2) feed(CL_NL + 5'($urandom_range(0, 1)), 1'b0);
                else
                    feed(CL_FF + 5'($urandom_range(0, 1)), 1'b0);
            end
        end
        text_in.valid <= 1'b0;

        // Drain, then wait for stray results
        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (ledger.mismatches == 0)
            $display("tb_text_word_line_paragraph_scanner_top: clean");
        else
            $display("tb_text_word_line_paragraph_scanner_top: errors");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #1_000_000;
        $display("tb_text_word_line_paragraph_scanner_top: errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/twlp_pkg.sv
hw/rtl/twlp_stream_if.sv
hw/rtl/text_word_line_paragraph_scanner_top.sv
verif/tb_text_word_line_paragraph_scanner_top.sv
